// ===== sv/rgbil_pkg.sv =====
package rgbil_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int IN_W      = INT_BITS + FRAC_BITS;
  // channel magnitude once negatives are zeroed
  localparam int MAG_W     = IN_W - 1;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int NUM_CH    = 3;

  localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] red_in;
    logic signed [IN_W-1:0] green_in;
    logic signed [IN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             was_scaled;
  } pixel_out_t;

endpackage

// ===== sv/rgb_intensity_limiter.sv =====
// RGB intensity limiter. Takes one pixel per clock whenever start is high;
// busy never rises, and each result appears on result for one cycle with
// done high, in input order. The receiver cannot stall the block. The
// pipeline depth is set by the hue-keeping divide: each channel goes
// through a restoring divider with one quotient bit per pipeline stage
// (17 stages), plus input, max-search and output registers. The
// preserve_color register resets to 1 and is written through the cfg
// channel, which is always ready; write it only while no pixel is
// in flight.
module rgb_intensity_limiter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  rgbil_pkg::pixel_in_t  pixel,
  output logic                  done,
  output rgbil_pkg::pixel_out_t result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int MAG_W  = rgbil_pkg::MAG_W;
  localparam int OUT_W  = rgbil_pkg::OUT_W;
  localparam int NUM_CH = rgbil_pkg::NUM_CH;
  localparam int IN_W   = rgbil_pkg::IN_W;
  localparam int NQ     = OUT_W;          // one quotient bit per stage
  localparam int LAT    = NQ + 3;

  logic preserve;

  // input stage
  logic             a_vld;
  logic             a_pres;
  logic [MAG_W-1:0] a_c [NUM_CH];
  logic [IN_W-1:0]  in_ch [NUM_CH];

  // divider pipeline, index 0 is the max-search stage
  logic             d_vld  [NQ+1];
  logic             d_sel  [NQ+1];
  logic             d_over [NQ+1];
  logic [MAG_W-1:0] d_mx   [NQ+1];
  logic [MAG_W-1:0] d_rem  [NQ+1][NUM_CH];
  logic [OUT_W-1:0] d_quo  [NQ+1][NUM_CH];
  logic [OUT_W-1:0] d_lim  [NQ+1][NUM_CH];

  logic [MAG_W:0]   t_div  [NQ][NUM_CH];
  logic             q_bit  [NQ][NUM_CH];
  logic [MAG_W-1:0] r_next [NQ][NUM_CH];

  logic [MAG_W-1:0] mx_next;
  logic             over_next;
  logic [OUT_W-1:0] lim_next [NUM_CH];
  logic [OUT_W-1:0] ch_out   [NUM_CH];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign in_ch[0] = pixel.red_in;
  assign in_ch[1] = pixel.green_in;
  assign in_ch[2] = pixel.blue_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      preserve <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      preserve <= cfg_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      done  <= 1'b0;
      for (int j = 0; j <= NQ; j++) begin
        d_vld[j] <= 1'b0;
      end
    end else begin
      a_vld    <= start && !busy;
      d_vld[0] <= a_vld;
      for (int j = 0; j < NQ; j++) begin
        d_vld[j+1] <= d_vld[j];
      end
      done <= d_vld[NQ];
    end
  end

  // negatives read as zero
  always_ff @(posedge clk) begin
    a_pres <= preserve;
    for (int i = 0; i < NUM_CH; i++) begin
      a_c[i] <= in_ch[i][IN_W-1] ? '0 : in_ch[i][MAG_W-1:0];
    end
  end

  always_comb begin
    mx_next   = a_c[0];
    over_next = 1'b0;
    for (int i = 1; i < NUM_CH; i++) begin
      if (a_c[i] > mx_next) begin
        mx_next = a_c[i];
      end
    end
    for (int i = 0; i < NUM_CH; i++) begin
      if (a_c[i] > MAG_W'(rgbil_pkg::ONE_FX)) begin
        over_next   = 1'b1;
        lim_next[i] = rgbil_pkg::ONE_FX;
      end else begin
        lim_next[i] = a_c[i][OUT_W-1:0];
      end
    end
  end

  // restoring divide of (c << FRAC_BITS) by the max; c <= max keeps rem < max
  always_comb begin
    for (int j = 0; j < NQ; j++) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (j == 0) begin
          t_div[j][i] = {1'b0, d_rem[j][i]};
        end else begin
          t_div[j][i] = {d_rem[j][i], 1'b0};
        end
        q_bit[j][i] = t_div[j][i] >= {1'b0, d_mx[j]};
        if (q_bit[j][i]) begin
          r_next[j][i] = MAG_W'(t_div[j][i] - {1'b0, d_mx[j]});
        end else begin
          r_next[j][i] = t_div[j][i][MAG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    d_sel[0]  <= a_pres && over_next;
    d_over[0] <= over_next;
    d_mx[0]   <= mx_next;
    for (int i = 0; i < NUM_CH; i++) begin
      d_rem[0][i] <= a_c[i];
      d_quo[0][i] <= '0;
      d_lim[0][i] <= lim_next[i];
    end
    for (int j = 0; j < NQ; j++) begin
      d_sel[j+1]  <= d_sel[j];
      d_over[j+1] <= d_over[j];
      d_mx[j+1]   <= d_mx[j];
      for (int i = 0; i < NUM_CH; i++) begin
        d_rem[j+1][i] <= r_next[j][i];
        d_quo[j+1][i] <= {d_quo[j][i][OUT_W-2:0], q_bit[j][i]};
        d_lim[j+1][i] <= d_lim[j][i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_out[i] = d_sel[NQ] ? d_quo[NQ][i] : d_lim[NQ][i];
    end
  end

  always_ff @(posedge clk) begin
    result.red_out    <= ch_out[0];
    result.green_out  <= ch_out[1];
    result.blue_out   <= ch_out[2];
    result.was_scaled <= d_over[NQ];
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("pixel did not come out after the pipeline latency");

  a_range : assert property (@(posedge clk) disable iff (rst)
    done |-> result.red_out <= rgbil_pkg::ONE_FX
          && result.green_out <= rgbil_pkg::ONE_FX
          && result.blue_out <= rgbil_pkg::ONE_FX)
    else $error("limited channel above 1.0");

  a_max_one : assert property (@(posedge clk) disable iff (rst)
    d_vld[NQ] && d_sel[NQ] |-> d_quo[NQ][0] == rgbil_pkg::ONE_FX
                             || d_quo[NQ][1] == rgbil_pkg::ONE_FX
                             || d_quo[NQ][2] == rgbil_pkg::ONE_FX)
    else $error("scaled pixel has no channel at 1.0");

  a_unscaled : assert property (@(posedge clk) disable iff (rst)
    done && !result.was_scaled |-> $past(!d_sel[NQ]))
    else $error("divide path used for a pixel within range");

endmodule
